>>> src/owm_pkg.sv
package owm_pkg;

  // Configuration register bank geometry.
  localparam int CFG_W     = 10;
  localparam int CFG_N     = 8;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_RECOVERY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_LOW       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_RECOVERY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DELAY   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_RECOVERY  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_DELAY = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] RST_SHORT_LOW      = 10'd6;
  localparam logic [CFG_W-1:0] RST_ONE_RECOVERY   = 10'd64;
  localparam logic [CFG_W-1:0] RST_LONG_LOW       = 10'd60;
  localparam logic [CFG_W-1:0] RST_ZERO_RECOVERY  = 10'd10;
  localparam logic [CFG_W-1:0] RST_SAMPLE_DELAY   = 10'd9;
  localparam logic [CFG_W-1:0] RST_READ_RECOVERY  = 10'd55;
  localparam logic [CFG_W-1:0] RST_RESET_LOW      = 10'd480;
  localparam logic [CFG_W-1:0] RST_PRESENCE_DELAY = 10'd70;

  // Defaults of the top-level parameters.
  localparam int DEF_RESET_TAIL_TICKS = 410;
  localparam int DEF_PRE_RESET_TICKS  = 0;
  localparam int DEF_COUNT_BITS       = 10;

  // Request codes; a command code also serves as the command kind.
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_RESET = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // Sequencer phase codes.
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_PRE   = 4'd1;
  localparam logic [3:0] PH_RLOW  = 4'd2;
  localparam logic [3:0] PH_RWAIT = 4'd3;
  localparam logic [3:0] PH_RSAMP = 4'd4;
  localparam logic [3:0] PH_RTAIL = 4'd5;
  localparam logic [3:0] PH_SLOW  = 4'd6;
  localparam logic [3:0] PH_SREC  = 4'd7;
  localparam logic [3:0] PH_DWAIT = 4'd8;
  localparam logic [3:0] PH_DSAMP = 4'd9;
  localparam logic [3:0] PH_DREC  = 4'd10;
  localparam logic [3:0] PH_END   = 4'd15;

  // Timing settings as seen by the sequencer.
  typedef struct packed {
    logic [CFG_W-1:0] short_low;
    logic [CFG_W-1:0] one_recovery;
    logic [CFG_W-1:0] long_low;
    logic [CFG_W-1:0] zero_recovery;
    logic [CFG_W-1:0] sample_delay;
    logic [CFG_W-1:0] read_recovery;
    logic [CFG_W-1:0] reset_low;
    logic [CFG_W-1:0] presence_delay;
  } owm_cfg_t;

endpackage

>>> src/owm_cfg.sv
module owm_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [owm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [owm_pkg::CFG_W-1:0]        cfg_data,
  output owm_pkg::owm_cfg_t                cfg
);
  import owm_pkg::*;

  // Writes are taken in any cycle.
  assign cfg_ready = 1'b1;

  // Register bank, one beat writes one register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_low      <= RST_SHORT_LOW;
      cfg.one_recovery   <= RST_ONE_RECOVERY;
      cfg.long_low       <= RST_LONG_LOW;
      cfg.zero_recovery  <= RST_ZERO_RECOVERY;
      cfg.sample_delay   <= RST_SAMPLE_DELAY;
      cfg.read_recovery  <= RST_READ_RECOVERY;
      cfg.reset_low      <= RST_RESET_LOW;
      cfg.presence_delay <= RST_PRESENCE_DELAY;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SHORT_LOW:      cfg.short_low      <= cfg_data;
        CFG_ONE_RECOVERY:   cfg.one_recovery   <= cfg_data;
        CFG_LONG_LOW:       cfg.long_low       <= cfg_data;
        CFG_ZERO_RECOVERY:  cfg.zero_recovery  <= cfg_data;
        CFG_SAMPLE_DELAY:   cfg.sample_delay   <= cfg_data;
        CFG_READ_RECOVERY:  cfg.read_recovery  <= cfg_data;
        CFG_RESET_LOW:      cfg.reset_low      <= cfg_data;
        CFG_PRESENCE_DELAY: cfg.presence_delay <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> src/one_wire_bus_master.sv
// Channel | Direction | Handshake            | Beat contents
// in      | to block  | in_valid / in_stall  | req_type, data_byte, line_level
// out     | from block| out_valid / out_stall| drive_low, done_res, presence,
//         |           |                      | read_value, busy_reject
// cfg     | to block  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One input beat per clock cycle while in_stall is low; each input beat gives exactly one output beat.
// An input beat passes through an input register, then one pass of the phase
// sequencer into the result register.
// Synchronous active-high reset clears the sequencer and the pipeline valids and
// loads the timing registers with reset values. A stalled output holds its beat,
// and in_stall rises in the same cycle once the input register also holds a beat.
module one_wire_bus_master #(
  parameter int RESET_TAIL_TICKS = owm_pkg::DEF_RESET_TAIL_TICKS,
  parameter int PRE_RESET_TICKS  = owm_pkg::DEF_PRE_RESET_TICKS,
  parameter int COUNT_BITS       = owm_pkg::DEF_COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    req_type,
  input  logic [7:0]                    data_byte,
  input  logic                          line_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          drive_low,
  output logic                          done_res,
  output logic                          presence,
  output logic [7:0]                    read_value,
  output logic                          busy_reject,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [owm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [owm_pkg::CFG_W-1:0]     cfg_data
);
  import owm_pkg::*;

  // Length compare width covers both the counter and the timing values.
  localparam int LW = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic [3:0] phase;
    logic [2:0] bit_index;
  } owm_pos_t;

  owm_cfg_t cfg;

  // Input register.
  logic       item_valid;
  logic [1:0] item_req;
  logic [7:0] item_data;
  logic       item_line;

  // Sequencer state.
  logic [3:0]            phase, phase_next;
  logic [COUNT_BITS-1:0] tick_count, tick_count_next;
  logic [2:0]            bit_index, bit_index_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic [1:0]            command_kind, command_kind_next;
  logic                  presence_seen, presence_seen_next;

  // Result of the current pass.
  logic       res_drive, res_done, res_pres, res_rej;
  logic [7:0] res_rval;

  logic out_load;
  logic item_take;

  owm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  function automatic logic [LW-1:0] at_least_one(input logic [CFG_W-1:0] v);
    at_least_one = (v == '0) ? LW'(1) : LW'(v);
  endfunction

  // Length of a phase in ticks.
  function automatic logic [LW-1:0] phase_len(input logic [3:0] ph, input logic [1:0] kind,
                                              input logic bit_val, input owm_cfg_t c);
    logic [LW-1:0] len;
    case (ph)
      PH_PRE:   len = LW'(PRE_RESET_TICKS);
      PH_RLOW:  len = at_least_one(c.reset_low);
      PH_RWAIT: len = LW'(c.presence_delay);
      PH_RSAMP: len = LW'(1);
      PH_RTAIL: len = LW'(RESET_TAIL_TICKS);
      PH_SLOW:  len = (kind == REQ_WRITE && !bit_val) ? at_least_one(c.long_low)
                                                      : at_least_one(c.short_low);
      PH_SREC:  len = bit_val ? LW'(c.one_recovery) : LW'(c.zero_recovery);
      PH_DWAIT: len = LW'(c.sample_delay);
      PH_DSAMP: len = LW'(1);
      PH_DREC:  len = LW'(c.read_recovery);
      default:  len = LW'(1);
    endcase
    phase_len = len;
  endfunction

  // Phase order; the end of a slot moves on to the next bit.
  function automatic owm_pos_t next_pos(input owm_pos_t p, input logic [1:0] kind);
    owm_pos_t n;
    n = p;
    case (p.phase)
      PH_PRE:   n.phase = PH_RLOW;
      PH_RLOW:  n.phase = PH_RWAIT;
      PH_RWAIT: n.phase = PH_RSAMP;
      PH_RSAMP: n.phase = PH_RTAIL;
      PH_SLOW:  n.phase = (kind == REQ_WRITE) ? PH_SREC : PH_DWAIT;
      PH_DWAIT: n.phase = PH_DSAMP;
      PH_DSAMP: n.phase = PH_DREC;
      PH_SREC, PH_DREC: begin
        if (p.bit_index == 3'd7) begin
          n.phase = PH_END;
        end else begin
          n.phase     = PH_SLOW;
          n.bit_index = p.bit_index + 3'd1;
        end
      end
      default:  n.phase = PH_END;
    endcase
    next_pos = n;
  endfunction

  // Every phase that may be empty is followed by one that is never empty or by
  // the end, so a single skip step is enough.
  function automatic owm_pos_t skip_empty(input owm_pos_t p, input logic [1:0] kind,
                                          input logic [7:0] sbyte, input owm_cfg_t c);
    if (p.phase != PH_END && phase_len(p.phase, kind, sbyte[p.bit_index], c) == '0) begin
      skip_empty = next_pos(p, kind);
    end else begin
      skip_empty = p;
    end
  endfunction

  // Pipeline flow control.
  assign out_load  = !out_valid || !out_stall;
  assign item_take = item_valid && out_load;
  assign in_stall  = item_valid && !out_load;

  // One pass of the sequencer for the item in the input register.
  always_comb begin
    owm_pos_t              pos;
    logic [7:0]            sb_upd;
    logic [COUNT_BITS-1:0] tc_inc;
    logic [LW-1:0]         len;

    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    command_kind_next  = command_kind;
    presence_seen_next = presence_seen;
    res_drive = 1'b0;
    res_done  = 1'b0;
    res_pres  = 1'b0;
    res_rval  = '0;
    res_rej   = 1'b0;
    pos       = '{phase: phase, bit_index: bit_index};
    sb_upd    = shift_byte;
    tc_inc    = tick_count + 1'b1;
    len       = '0;

    if (item_take) begin
      if (item_req != REQ_TICK) begin
        if (phase != PH_IDLE) begin
          // Command while busy: rejected, state holds.
          res_rej   = 1'b1;
          res_drive = (phase == PH_RLOW) || (phase == PH_SLOW);
        end else begin
          // Command start.
          sb_upd             = (item_req == REQ_WRITE) ? item_data : 8'd0;
          pos.phase          = (item_req == REQ_RESET) ? PH_PRE : PH_SLOW;
          pos.bit_index      = 3'd0;
          pos                = skip_empty(pos, item_req, sb_upd, cfg);
          command_kind_next  = item_req;
          tick_count_next    = '0;
          presence_seen_next = 1'b0;
          shift_byte_next    = sb_upd;
          phase_next         = pos.phase;
          bit_index_next     = pos.bit_index;
        end
      end else if (phase != PH_IDLE) begin
        // Tick: sample, count, and move on at the end of a phase.
        res_drive = (phase == PH_RLOW) || (phase == PH_SLOW);
        len = phase_len(phase, command_kind, shift_byte[bit_index], cfg);
        if (phase == PH_RSAMP) begin
          presence_seen_next = !item_line;
        end
        if (phase == PH_DSAMP) begin
          sb_upd[bit_index] = shift_byte[bit_index] | item_line;
        end
        shift_byte_next = sb_upd;
        if (LW'(tc_inc) >= len || tc_inc == CMAX) begin
          tick_count_next = '0;
          pos = skip_empty(next_pos(pos, command_kind), command_kind, sb_upd, cfg);
        end else begin
          tick_count_next = tc_inc;
        end
        phase_next     = pos.phase;
        bit_index_next = pos.bit_index;
        if (pos.phase == PH_END) begin
          res_done        = 1'b1;
          res_pres        = (command_kind == REQ_RESET) ? presence_seen_next : 1'b0;
          res_rval        = (command_kind == REQ_READ) ? sb_upd : 8'd0;
          phase_next      = PH_IDLE;
          tick_count_next = '0;
          bit_index_next  = 3'd0;
        end
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (item_take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_req  <= req_type;
      item_data <= data_byte;
      item_line <= line_level;
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_index     <= 3'd0;
      shift_byte    <= 8'd0;
      command_kind  <= REQ_TICK;
      presence_seen <= 1'b0;
    end else begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      command_kind  <= command_kind_next;
      presence_seen <= presence_seen_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      drive_low   <= res_drive;
      done_res    <= res_done;
      presence    <= res_pres;
      read_value  <= res_rval;
      busy_reject <= res_rej;
    end
  end

`ifndef SYNTHESIS
  // A rejected command never finishes anything.
  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && busy_reject |-> !done_res && !presence && read_value == 8'd0)
    else $error("rejected beat carries completion data");

  // Presence is only reported with done.
  a_presence_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && presence |-> done_res)
    else $error("presence reported off the done beat");

  // An idle sequencer has its counters cleared.
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> tick_count == '0 && bit_index == 3'd0)
    else $error("idle sequencer with live counters");

  // A completing pass always returns the sequencer to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    item_take && res_done |=> phase == PH_IDLE)
    else $error("sequencer not idle after done");
`endif

endmodule
